// ===== sv/tdls_pkg.sv =====
// Shared types and codes for the trace-driven link shaper.
package tdls_pkg;

  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_APPEND = 2'd2;

  localparam logic [1:0] KIND_ANS = 2'd0;
  localparam logic [1:0] KIND_PKT = 2'd1;
  localparam logic [1:0] KIND_FIN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QFULL = 2'd1;
  localparam logic [1:0] ST_SFULL = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  localparam int unsigned DIV_STEPS = 48;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANS,
    S_RD,
    S_EVAL,
    S_DIV,
    S_PKT,
    S_PWAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic cap;
    logic do_ans;
    logic adv_slot;
    logic div_start;
    logic div_apply;
    logic load_bytes;
    logic pop;
    logic part;
    logic emit_fin;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic sched_empty;
    logic q_empty;
    logic slot_late;
    logic p_zero;
    logic catchup_ok;
    logic bytes_zero;
    logic rem_fits;
    logic div_done;
    logic ofree;
  } stat_t;

endpackage

// ===== sv/tdls_ctrl.sv =====
// Sequencer for requests and the tick delivery loop.
module tdls_ctrl #(
  parameter int unsigned MAX_OUT = 63
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tdls_pkg::stat_t st,
  output tdls_pkg::cmd_t  cmd
);

  tdls_pkg::state_t state_r, state_nxt;
  logic [5:0] n_r, n_nxt;
  logic       n_max;

  assign n_max = (n_r == 6'(MAX_OUT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdls_pkg::S_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tdls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = tdls_pkg::S_ANS;
        end
      end
      tdls_pkg::S_ANS: begin
        if (st.req_tick) begin
          n_nxt     = '0;
          state_nxt = tdls_pkg::S_RD;
        end else if (st.ofree) begin
          cmd.do_ans = 1'b1;
          state_nxt  = tdls_pkg::S_IDLE;
        end
      end
      // schedule entry read settles
      tdls_pkg::S_RD: state_nxt = tdls_pkg::S_EVAL;
      tdls_pkg::S_EVAL: begin
        if (st.sched_empty || n_max || st.slot_late) begin
          state_nxt = tdls_pkg::S_FIN;
        end else if (st.q_empty) begin
          if (st.p_zero) begin
            state_nxt = tdls_pkg::S_FIN;
          end else if (st.catchup_ok) begin
            cmd.div_start = 1'b1;
            state_nxt     = tdls_pkg::S_DIV;
          end else begin
            cmd.adv_slot = 1'b1;
            state_nxt    = tdls_pkg::S_RD;
          end
        end else begin
          cmd.adv_slot   = 1'b1;
          cmd.load_bytes = 1'b1;
          state_nxt      = tdls_pkg::S_PKT;
        end
      end
      tdls_pkg::S_DIV: begin
        if (st.div_done) begin
          cmd.div_apply = 1'b1;
          state_nxt     = tdls_pkg::S_RD;
        end
      end
      tdls_pkg::S_PKT: begin
        if (st.bytes_zero || st.q_empty || n_max) begin
          state_nxt = tdls_pkg::S_RD;
        end else if (st.rem_fits) begin
          if (st.ofree) begin
            cmd.pop   = 1'b1;
            n_nxt     = n_r + 6'd1;
            state_nxt = tdls_pkg::S_PWAIT;
          end
        end else begin
          cmd.part  = 1'b1;
          state_nxt = tdls_pkg::S_RD;
        end
      end
      // new head entry read settles
      tdls_pkg::S_PWAIT: state_nxt = tdls_pkg::S_PKT;
      tdls_pkg::S_FIN: begin
        if (st.ofree) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = tdls_pkg::S_IDLE;
        end
      end
      default: state_nxt = tdls_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/tdls_dp.sv =====
// Datapath: schedule and packet memories, timing state, remainder unit, result register.
module tdls_dp #(
  parameter int unsigned OPPORTUNITY_BYTES = 1504,
  parameter int unsigned SCHEDULE_DEPTH    = 1024,
  parameter int unsigned QUEUE_DEPTH       = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_req_type,
  input  logic [15:0]     in_packet_tag,
  input  logic [15:0]     in_packet_bytes,
  input  logic [47:0]     in_now_ms,
  input  logic [31:0]     in_sched_offset,
  input  tdls_pkg::cmd_t  cmd,
  output tdls_pkg::stat_t st,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [1:0]      out_status,
  output logic [15:0]     out_tag,
  output logic [15:0]     out_wait_ms,
  output logic            out_last
);

  localparam int unsigned SAW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(SCHEDULE_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  // captured request
  logic [1:0]  req_r;
  logic [15:0] tag_r, len_r;
  logic [47:0] now_r;
  logic [31:0] off_r;

  logic [31:0] sched_mem [SCHEDULE_DEPTH];
  logic [31:0] s_rd_r;
  logic [15:0] qtag_mem [QUEUE_DEPTH];
  logic [16:0] qrem_mem [QUEUE_DEPTH];
  logic [15:0] q_tag_rd_r;
  logic [16:0] q_rem_rd_r;

  logic [SCW-1:0] scount_r;
  logic [SAW-1:0] slot_r;
  logic [47:0]    base_r;
  logic [31:0]    last_off_r;
  logic [QAW-1:0] head_r, tail_r;
  logic [QCW-1:0] qcount_r;
  logic [15:0]    bytes_r;

  logic [47:0] dvd_r;
  logic [31:0] rem_r;
  logic [5:0]  div_cnt_r;
  logic        div_busy_r;

  logic        out_valid_r, out_last_r;
  logic [1:0]  out_kind_r, out_status_r;
  logic [15:0] out_tag_r, out_wait_r;

  logic        ofree, q_full, s_full, s_order;
  logic [1:0]  ans_status;
  logic [48:0] slot_time, catch_time, wait_diff;
  logic [15:0] wait_val;
  logic [32:0] div_t;
  logic [SAW-1:0] slot_inc;
  logic        slot_wrap;
  logic [QAW-1:0] head_inc, tail_inc;

  assign ofree   = !out_valid_r || out_ready;
  assign q_full  = (qcount_r == QCW'(QUEUE_DEPTH));
  assign s_full  = (scount_r == SCW'(SCHEDULE_DEPTH));
  assign s_order = (scount_r != '0) && (off_r < last_off_r);

  always_comb begin
    if (req_r == tdls_pkg::REQ_ENQ && q_full)         ans_status = tdls_pkg::ST_QFULL;
    else if (req_r == tdls_pkg::REQ_APPEND && s_full) ans_status = tdls_pkg::ST_SFULL;
    else if (req_r == tdls_pkg::REQ_APPEND && s_order) ans_status = tdls_pkg::ST_ORDER;
    else                                               ans_status = tdls_pkg::ST_OK;
  end

  assign slot_time  = {1'b0, base_r} + {17'd0, s_rd_r};
  assign catch_time = {1'b0, base_r} + {17'd0, last_off_r};
  assign slot_wrap  = ({{(SCW - SAW){1'b0}}, slot_r} + SCW'(1)) == scount_r;
  assign slot_inc   = slot_wrap ? '0 : slot_r + SAW'(1);
  assign head_inc   = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QAW'(1);
  assign tail_inc   = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QAW'(1);
  assign div_t      = {rem_r, dvd_r[47]};
  assign wait_diff  = slot_time - {1'b0, now_r};

  always_comb begin
    if (qcount_r == '0 || scount_r == '0)  wait_val = 16'hFFFF;
    else if (slot_time <= {1'b0, now_r})   wait_val = 16'd0;
    else if (wait_diff > 49'h0FFFF)         wait_val = 16'hFFFF;
    else                                    wait_val = wait_diff[15:0];
  end

  always_comb begin
    st.req_tick    = (req_r == tdls_pkg::REQ_TICK);
    st.sched_empty = (scount_r == '0);
    st.q_empty     = (qcount_r == '0);
    st.slot_late   = slot_time > {1'b0, now_r};
    st.p_zero      = (last_off_r == '0);
    st.catchup_ok  = (slot_r == '0) && (catch_time <= {1'b0, now_r});
    st.bytes_zero  = (bytes_r == '0);
    st.rem_fits    = q_rem_rd_r <= {1'b0, bytes_r};
    st.div_done    = !div_busy_r;
    st.ofree       = ofree;
  end

  // memories
  always_ff @(posedge clk) begin
    s_rd_r <= sched_mem[slot_r];
    if (cmd.do_ans && req_r == tdls_pkg::REQ_APPEND && !s_full && !s_order)
      sched_mem[scount_r[SAW-1:0]] <= off_r;
  end

  always_ff @(posedge clk) begin
    q_tag_rd_r <= qtag_mem[head_r];
    q_rem_rd_r <= qrem_mem[head_r];
    if (cmd.do_ans && req_r == tdls_pkg::REQ_ENQ && !q_full) begin
      qtag_mem[tail_r] <= tag_r;
      qrem_mem[tail_r] <= {1'b0, len_r};
    end else if (cmd.part) begin
      qrem_mem[head_r] <= q_rem_rd_r - {1'b0, bytes_r};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      tag_r <= in_packet_tag;
      len_r <= in_packet_bytes;
      now_r <= in_now_ms;
      off_r <= in_sched_offset;
    end
    if (cmd.do_ans && req_r == tdls_pkg::REQ_APPEND && !s_full && !s_order)
      last_off_r <= off_r;
    if (cmd.load_bytes) bytes_r <= 16'(OPPORTUNITY_BYTES);
    else if (cmd.pop)   bytes_r <= bytes_r - q_rem_rd_r[15:0];
    else if (cmd.part)  bytes_r <= '0;
    // remainder of (now - base) by the period, one bit per cycle
    if (cmd.div_start) begin
      dvd_r <= now_r - base_r;
      rem_r <= '0;
    end else if (div_busy_r) begin
      dvd_r <= {dvd_r[46:0], 1'b0};
      rem_r <= (div_t >= {1'b0, last_off_r}) ? 32'(div_t - {1'b0, last_off_r})
                                             : div_t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scount_r   <= '0;
      slot_r     <= '0;
      base_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      qcount_r   <= '0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      if (cmd.do_ans && req_r == tdls_pkg::REQ_APPEND && !s_full && !s_order)
        scount_r <= scount_r + SCW'(1);
      if (cmd.do_ans && req_r == tdls_pkg::REQ_ENQ && !q_full) begin
        tail_r   <= tail_inc;
        qcount_r <= qcount_r + QCW'(1);
      end else if (cmd.pop) begin
        head_r   <= head_inc;
        qcount_r <= qcount_r - QCW'(1);
      end
      if (cmd.adv_slot) begin
        slot_r <= slot_inc;
        if (slot_wrap) base_r <= catch_time[47:0];
      end else if (cmd.div_apply) begin
        base_r <= now_r - {16'd0, rem_r};
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= 6'(tdls_pkg::DIV_STEPS - 1);
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r - 6'd1;
        if (div_cnt_r == '0) div_busy_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_ans || cmd.pop || cmd.emit_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_ans) begin
      out_kind_r   <= tdls_pkg::KIND_ANS;
      out_status_r <= ans_status;
      out_tag_r    <= '0;
      out_wait_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.pop) begin
      out_kind_r   <= tdls_pkg::KIND_PKT;
      out_status_r <= tdls_pkg::ST_OK;
      out_tag_r    <= q_tag_rd_r;
      out_wait_r   <= '0;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_fin) begin
      out_kind_r   <= tdls_pkg::KIND_FIN;
      out_status_r <= tdls_pkg::ST_OK;
      out_tag_r    <= '0;
      out_wait_r   <= wait_val;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_status  = out_status_r;
  assign out_tag     = out_tag_r;
  assign out_wait_ms = out_wait_r;
  assign out_last    = out_last_r;

endmodule

// ===== sv/trace_driven_link_shaper_core.sv =====
// Link shaper: packets delivered at opportunities taken from a repeating recorded schedule.
// Enqueue, append and unknown requests: the request is captured, then the answer is registered.
// Tick: opportunities are read and examined in turn; a served one delivers queued packets, each
//   as its own result, then a finish result closes the tick; an idle catch-up over whole rounds
//   runs in a bit-serial remainder unit. Result stalls hold the sequencer until the output is free.
// One item is in work at a time; in_ready is high only when the sequencer is idle.
module trace_driven_link_shaper_core #(
  parameter int unsigned OPPORTUNITY_BYTES = 1504,
  parameter int unsigned SCHEDULE_DEPTH    = 1024,
  parameter int unsigned QUEUE_DEPTH       = 64,
  parameter int unsigned MAX_OUT           = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_packet_tag,
  input  logic [15:0] in_packet_bytes,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_sched_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic [15:0] out_wait_ms,
  output logic        out_last
);

  // rst_n (synchronous, active low) clears counters, pointers, base time and the result valid.

  tdls_pkg::cmd_t  cmd;
  tdls_pkg::stat_t st;

  tdls_ctrl #(.MAX_OUT(MAX_OUT)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tdls_dp #(
    .OPPORTUNITY_BYTES (OPPORTUNITY_BYTES),
    .SCHEDULE_DEPTH    (SCHEDULE_DEPTH),
    .QUEUE_DEPTH       (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_packet_tag   (in_packet_tag),
    .in_packet_bytes (in_packet_bytes),
    .in_now_ms       (in_now_ms),
    .in_sched_offset (in_sched_offset),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_wait_ms     (out_wait_ms),
    .out_last        (out_last)
  );

endmodule

// ===== sv/tdls_checker.sv =====
// Port-level checks for the link shaper, bound to the top level.
module tdls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_status,
  input logic [15:0] out_tag,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_kind))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_pkt_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tdls_pkg::KIND_PKT |-> !out_last && out_status == tdls_pkg::ST_OK)
    else $error("delivered packet marked last or with status");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == tdls_pkg::KIND_FIN || out_kind == tdls_pkg::KIND_ANS)
    |-> out_last)
    else $error("closing result without last");

endmodule

bind trace_driven_link_shaper_core tdls_checker u_tdls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_kind   (out_kind),
  .out_status (out_status),
  .out_tag    (out_tag),
  .out_last   (out_last)
);
